@@ hw/rtl/nmu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmu_pkg: shared constants and functions of the nimber multiplier
// Small-field nim products and the constant multiplies that fold a high*high
// product back into the low half at each level of the field tower.
// ----------------------------------------------------------------------------
package nmu_pkg;

  localparam int WORD_BITS_DEFAULT = 64;
  localparam int LATENCY = 8;

  // Nim product in the 2-bit field.
  function automatic logic [1:0] nim2(input logic [1:0] a, input logic [1:0] b);
    nim2 = {(a[0] & b[1]) ^ (a[1] & b[0]) ^ (a[1] & b[1]),
            (a[0] & b[0]) ^ (a[1] & b[1])};
  endfunction

  // Multiply by 2 in the 2-bit field.
  function automatic logic [1:0] mulc2(input logic [1:0] x);
    mulc2 = {x[0] ^ x[1], x[1]};
  endfunction

  // Nim product in the 4-bit field, middle term by the Karatsuba form.
  function automatic logic [3:0] nim4(input logic [3:0] a, input logic [3:0] b);
    logic [1:0] hh, mm, ll;
    hh = nim2(a[3:2], b[3:2]);
    mm = nim2(a[3:2] ^ a[1:0], b[3:2] ^ b[1:0]);
    ll = nim2(a[1:0], b[1:0]);
    nim4 = {mm ^ ll, mulc2(hh) ^ ll};
  endfunction

  // Multiply by the top bit of the field, one function per width.
  function automatic logic [3:0] mulc4(input logic [3:0] x);
    logic [1:0] hh;
    hh = mulc2(x[3:2]);
    mulc4 = {hh ^ mulc2(x[1:0]), mulc2(hh)};
  endfunction

  function automatic logic [7:0] mulc8(input logic [7:0] x);
    logic [3:0] hh;
    hh = mulc4(x[7:4]);
    mulc8 = {hh ^ mulc4(x[3:0]), mulc4(hh)};
  endfunction

  function automatic logic [15:0] mulc16(input logic [15:0] x);
    logic [7:0] hh;
    hh = mulc8(x[15:8]);
    mulc16 = {hh ^ mulc8(x[7:0]), mulc8(hh)};
  endfunction

  function automatic logic [31:0] mulc32(input logic [31:0] x);
    logic [15:0] hh;
    hh = mulc16(x[31:16]);
    mulc32 = {hh ^ mulc16(x[15:0]), mulc16(hh)};
  endfunction

endpackage

@@ hw/rtl/nimber_multiplier_64_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nimber_multiplier_64_unit: pipelined 64-bit nim multiplier
// Returns the nim product of two operands in the nimber field of order 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   Drive multiplicand_a / multiplicand_b and raise start for one cycle per
//   item. An item is taken at every edge where start is high and busy is low;
//   busy is tied low, so one item enters every cycle.
//   The product shows on nim_product with done high for exactly one cycle
//   once the item has passed all stages. Results leave in accept order.
//   Throughput is one item per clock; the pipeline has eight stages:
//   three split levels (64->32->16->8), one 4-bit table level, and four
//   combine levels (8, 16, 32, 64 bits).
//   Each level uses the Karatsuba form: hi = mid ^ low, lo = high*2^(h-1)^low,
//   so a 64-bit product is built from 81 small 4-bit products.
//   The receiver cannot stall; done is a strobe and must be sampled.
//   Reset clears the valid pipe only; items in flight are dropped.
//   Operand bits at and above WORD_BITS are masked off; narrower widths sit
//   in a subfield, so the full 64-bit datapath gives the same product.
// ----------------------------------------------------------------------------
module nimber_multiplier_64_unit #(
  parameter int WORD_BITS = nmu_pkg::WORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] multiplicand_a,
  input  logic [63:0] multiplicand_b,
  output logic        done,
  output logic [63:0] nim_product
);
  import nmu_pkg::*;

  localparam logic [63:0] OP_MASK =
    (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

  logic [LATENCY-1:0] vld;
  logic [63:0] am, bm;

  // split levels
  logic [31:0] a1 [3];
  logic [31:0] b1 [3];
  logic [15:0] a2 [9];
  logic [15:0] b2 [9];
  logic [7:0]  a3 [27];
  logic [7:0]  b3 [27];
  // product levels
  logic [3:0]  p4 [81];
  logic [7:0]  p5 [27];
  logic [15:0] p6 [9];
  logic [31:0] p7 [3];
  logic [63:0] p8;

  assign busy = 1'b0;
  assign am = multiplicand_a & OP_MASK;
  assign bm = multiplicand_b & OP_MASK;

  // Advance valid bits alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  // Split: child 0 takes the high halves, child 1 their sums, child 2 the low.
  always_ff @(posedge clk) begin
    a1[0] <= am[63:32];
    a1[1] <= am[63:32] ^ am[31:0];
    a1[2] <= am[31:0];
    b1[0] <= bm[63:32];
    b1[1] <= bm[63:32] ^ bm[31:0];
    b1[2] <= bm[31:0];
    for (int p = 0; p < 3; p++) begin
      a2[3*p]   <= a1[p][31:16];
      a2[3*p+1] <= a1[p][31:16] ^ a1[p][15:0];
      a2[3*p+2] <= a1[p][15:0];
      b2[3*p]   <= b1[p][31:16];
      b2[3*p+1] <= b1[p][31:16] ^ b1[p][15:0];
      b2[3*p+2] <= b1[p][15:0];
    end
    for (int p = 0; p < 9; p++) begin
      a3[3*p]   <= a2[p][15:8];
      a3[3*p+1] <= a2[p][15:8] ^ a2[p][7:0];
      a3[3*p+2] <= a2[p][7:0];
      b3[3*p]   <= b2[p][15:8];
      b3[3*p+1] <= b2[p][15:8] ^ b2[p][7:0];
      b3[3*p+2] <= b2[p][7:0];
    end
    // Last split feeds the 4-bit products directly.
    for (int p = 0; p < 27; p++) begin
      p4[3*p]   <= nim4(a3[p][7:4], b3[p][7:4]);
      p4[3*p+1] <= nim4(a3[p][7:4] ^ a3[p][3:0], b3[p][7:4] ^ b3[p][3:0]);
      p4[3*p+2] <= nim4(a3[p][3:0], b3[p][3:0]);
    end
  end

  // Combine: hi = mid ^ low, lo = mulc(high) ^ low.
  always_ff @(posedge clk) begin
    for (int p = 0; p < 27; p++) begin
      p5[p] <= {p4[3*p+1] ^ p4[3*p+2], mulc4(p4[3*p]) ^ p4[3*p+2]};
    end
    for (int p = 0; p < 9; p++) begin
      p6[p] <= {p5[3*p+1] ^ p5[3*p+2], mulc8(p5[3*p]) ^ p5[3*p+2]};
    end
    for (int p = 0; p < 3; p++) begin
      p7[p] <= {p6[3*p+1] ^ p6[3*p+2], mulc16(p6[3*p]) ^ p6[3*p+2]};
    end
    p8 <= {p7[1] ^ p7[2], mulc32(p7[0]) ^ p7[2]};
  end

  assign done        = vld[LATENCY-1];
  assign nim_product = p8;

endmodule

@@ hw/rtl/nmu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmu_checker: port-level checks of the nimber multiplier
// Watches handshake timing and simple algebraic identities of the product.
// ----------------------------------------------------------------------------
module nmu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [63:0] multiplicand_a,
  input logic [63:0] multiplicand_b,
  input logic        done,
  input logic [63:0] nim_product
);
  import nmu_pkg::*;

  // The pipe takes an item every cycle.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // Every result traces back to an accepted item.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  // Zero operand gives zero product.
  a_zero_a: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(multiplicand_a, LATENCY) == 64'd0)) |-> (nim_product == 64'd0))
    else $error("zero operand a gave nonzero product");

  a_zero_b: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(multiplicand_b, LATENCY) == 64'd0)) |-> (nim_product == 64'd0))
    else $error("zero operand b gave nonzero product");

endmodule

bind nimber_multiplier_64_unit nmu_checker u_nmu_checker (.*);
